// File: sv/mwhf_pkg.sv
// ----------------------------------------------------------------------------
// mwhf_pkg
// Shared types and constants of the memory watch hook filter.
// ----------------------------------------------------------------------------
package mwhf_pkg;

  localparam int unsigned MAX_WATCHES = 64;
  localparam int unsigned HOOK_KINDS  = 3;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SIZE_W  = 5;
  localparam int unsigned VALUE_W = 8;
  localparam int unsigned END_W   = ADDR_W + 1;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic                vld;
    cmd_e                cmd;
    logic [KIND_W-1:0]   kind;
    logic [ADDR_W-1:0]   addr;
    logic [END_W-1:0]    end_addr;
    logic                flag;
  } tok_t;

endpackage

// File: sv/mwhf_cell.sv
// ----------------------------------------------------------------------------
// mwhf_cell
// One watch entry: holds an address, a hook kind and a valid bit, applies the
// passing token to its entry and hands the token on to the next cell.
// ----------------------------------------------------------------------------
module mwhf_cell
  import mwhf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  logic              valid_q, valid_d;
  logic [ADDR_W-1:0] addr_q;
  logic [KIND_W-1:0] kind_q;
  tok_t              tok_q, tok_d;
  logic              wr_en;
  logic              kind_match;
  logic              in_range;

  always_comb begin
    tok_d      = tok_i;
    valid_d    = valid_q;
    wr_en      = 1'b0;
    kind_match = valid_q && (kind_q == tok_i.kind);
    in_range   = (addr_q >= tok_i.addr) && (END_W'(addr_q) < tok_i.end_addr);
    if (tok_i.vld) begin
      unique case (tok_i.cmd)
        CMD_CLEAR: begin
          if (kind_match) begin
            valid_d = 1'b0;
          end
        end
        CMD_ADD: begin
          // The first free cell along the row takes the address.
          if (!valid_q && !tok_i.flag) begin
            wr_en      = 1'b1;
            valid_d    = 1'b1;
            tok_d.flag = 1'b1;
          end
        end
        CMD_CHECK: begin
          if (kind_match && in_range) begin
            tok_d.flag = 1'b1;
          end
        end
        CMD_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      addr_q <= tok_i.addr;
      kind_q <= tok_i.kind;
    end
  end

  assign tok_o = tok_q;

endmodule

// File: sv/mwhf_chain.sv
// ----------------------------------------------------------------------------
// mwhf_chain
// Row of watch cells; the token enters at cell zero and leaves after the
// last cell with its flag settled.
// ----------------------------------------------------------------------------
module mwhf_chain
  import mwhf_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  tok_t tok_i,
  output tok_t tok_o
);

  tok_t link [MAX_WATCHES+1];

  assign link[0] = tok_i;

  for (genvar g = 0; g < MAX_WATCHES; g++) begin : g_cell
    mwhf_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .tok_i (link[g]),
      .tok_o (link[g+1])
    );
  end

  assign tok_o = link[MAX_WATCHES];

endmodule

// File: sv/memory_watch_hook_filter.sv
// ----------------------------------------------------------------------------
// memory_watch_hook_filter
// Watchpoint filter: keeps watched byte addresses per hook kind and reports
// accesses that touch a watched byte of their kind.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Fields
//  command   start / busy         cmd_i hook_kind_i address_i access_size_i
//                                 access_value_i
//  result    result_valid_o       hit_o table_full_o hit_address_o
//                                 hit_size_o hit_value_o hit_kind_o
//
// The result strobe comes once the token has passed the input register, each cell
// of the row in turn and the result register.
// busy is high from the accepting edge until the result cycle, in which a new
// item may already be started. Reset clears all valid bits at once, so the block
// takes items right after reset. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module memory_watch_hook_filter
  import mwhf_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd_i,
  input  logic [KIND_W-1:0]  hook_kind_i,
  input  logic [ADDR_W-1:0]  address_i,
  input  logic [SIZE_W-1:0]  access_size_i,
  input  logic [VALUE_W-1:0] access_value_i,
  output logic               result_valid_o,
  output logic               hit_o,
  output logic               table_full_o,
  output logic [ADDR_W-1:0]  hit_address_o,
  output logic [SIZE_W-1:0]  hit_size_o,
  output logic [VALUE_W-1:0] hit_value_o,
  output logic [KIND_W-1:0]  hit_kind_o
);

  logic               accept;
  logic               busy_q, busy_d;
  tok_t               tok_in_q, tok_in_d;
  tok_t               tok_out;
  logic [ADDR_W-1:0]  addr_q;
  logic [SIZE_W-1:0]  size_q;
  logic [VALUE_W-1:0] value_q;
  logic [KIND_W-1:0]  kind_q;
  logic               kind_ok;
  logic               res_vld_q, res_vld_d;
  logic               hit_q, hit_d;
  logic               full_q, full_d;
  logic [ADDR_W-1:0]  hit_addr_q, hit_addr_d;
  logic [SIZE_W-1:0]  hit_size_q, hit_size_d;
  logic [VALUE_W-1:0] hit_value_q, hit_value_d;
  logic [KIND_W-1:0]  hit_kind_q, hit_kind_d;

  assign accept  = start && !busy_q;
  assign kind_ok = (KIND_W+1)'(hook_kind_i) < (KIND_W+1)'(HOOK_KINDS);

  always_comb begin
    tok_in_d          = '0;
    tok_in_d.vld      = accept;
    // An item of an unknown hook kind walks the row without effect.
    tok_in_d.cmd      = kind_ok ? cmd_e'(cmd_i) : CMD_NONE;
    tok_in_d.kind     = hook_kind_i;
    tok_in_d.addr     = address_i;
    tok_in_d.end_addr = END_W'(address_i) + END_W'(access_size_i);
    tok_in_d.flag     = 1'b0;
  end

  mwhf_chain u_chain (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .tok_i (tok_in_q),
    .tok_o (tok_out)
  );

  always_comb begin
    busy_d      = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (tok_out.vld) begin
      busy_d = 1'b0;
    end
    res_vld_d   = tok_out.vld;
    hit_d       = tok_out.vld && (tok_out.cmd == CMD_CHECK) && tok_out.flag;
    full_d      = tok_out.vld && (tok_out.cmd == CMD_ADD) && !tok_out.flag;
    hit_addr_d  = hit_d ? addr_q  : '0;
    hit_size_d  = hit_d ? size_q  : '0;
    hit_value_d = hit_d ? value_q : '0;
    hit_kind_d  = hit_d ? kind_q  : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      tok_in_q  <= '0;
      res_vld_q <= 1'b0;
      hit_q     <= 1'b0;
      full_q    <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      tok_in_q  <= tok_in_d;
      res_vld_q <= res_vld_d;
      hit_q     <= hit_d;
      full_q    <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q  <= address_i;
      size_q  <= access_size_i;
      value_q <= access_value_i;
      kind_q  <= hook_kind_i;
    end
    hit_addr_q  <= hit_addr_d;
    hit_size_q  <= hit_size_d;
    hit_value_q <= hit_value_d;
    hit_kind_q  <= hit_kind_d;
  end

  assign busy           = busy_q;
  assign result_valid_o = res_vld_q;
  assign hit_o          = hit_q;
  assign table_full_o   = full_q;
  assign hit_address_o  = hit_addr_q;
  assign hit_size_o     = hit_size_q;
  assign hit_value_o    = hit_value_q;
  assign hit_kind_o     = hit_kind_q;

`ifndef NO_ASSERTIONS
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q)
    else $error("busy not raised after an accepted item");

  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q |-> !busy_q)
    else $error("busy still high in the result cycle");

  a_exit_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_out.vld |=> (res_vld_q && $past(busy_q)))
    else $error("token left the row without a pending item");

  a_hit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(hit_q && full_q))
    else $error("hit and table_full raised together");

  a_flag_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hit_q || full_q) |-> res_vld_q)
    else $error("result flag outside the result strobe");
`endif

endmodule

// File: sim/tb_memory_watch_hook_filter.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_memory_watch_hook_filter
// Self-checking testbench for the watchpoint filter. A short table of
// directed items is followed by random items. Each accepted item updates a
// local copy of the watch table, and every result strobe is checked against
// the oldest expected result.
// ----------------------------------------------------------------------------
module tb_memory_watch_hook_filter;
  import mwhf_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1780;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = MAX_WATCHES + 16;
  localparam int unsigned MAX_GAP      = 100;
  localparam int unsigned PHASE_ITEMS  = 240;
  localparam int unsigned IDLE_PCT [4] = '{0, 52, 0, 14};

  typedef struct packed {
    cmd_e               cmd;
    logic [KIND_W-1:0]  kind;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
    logic [VALUE_W-1:0] value;
  } access_item_t;

  typedef struct packed {
    logic               hit;
    logic               table_full;
    logic [ADDR_W-1:0]  addr;
    logic [SIZE_W-1:0]  size;
    logic [VALUE_W-1:0] value;
    logic [KIND_W-1:0]  kind;
  } filter_result_t;

  typedef struct packed {
    access_item_t   item;
    logic           typed;
    filter_result_t want;
  } directed_row_t;

  localparam filter_result_t NO_RESULT = '0;

  localparam int unsigned DIRECTED_N = 24;
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    '{'{CMD_CHECK, 2'd0, 16'h0000, 5'd16, 8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_ADD,   2'd0, 16'h0000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_ADD,   2'd0, 16'hFFFF, 5'd16, 8'hFF}, 1'b1, NO_RESULT},
    '{'{CMD_ADD,   2'd1, 16'h1000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_ADD,   2'd2, 16'h8000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd0, 16'h0000, 5'd1,  8'h5A}, 1'b0, NO_RESULT},
    '{'{CMD_CHECK, 2'd0, 16'hFFF0, 5'd16, 8'hA5}, 1'b0, NO_RESULT},
    '{'{CMD_CHECK, 2'd0, 16'hFFFF, 5'd16, 8'hFF}, 1'b0, NO_RESULT},
    '{'{CMD_CHECK, 2'd0, 16'hFFFF, 5'd0,  8'h3C}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd0, 16'hFFFF, 5'd31, 8'hC3}, 1'b0, NO_RESULT},
    '{'{CMD_CHECK, 2'd1, 16'h0FF1, 5'd15, 8'h11}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd1, 16'h0FF1, 5'd16, 8'h22}, 1'b0, NO_RESULT},
    '{'{CMD_CHECK, 2'd2, 16'h8000, 5'd1,  8'hFF}, 1'b0, NO_RESULT},
    '{'{CMD_CHECK, 2'd1, 16'h8000, 5'd1,  8'hFF}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd3, 16'h0000, 5'd31, 8'hFF}, 1'b1, NO_RESULT},
    '{'{CMD_ADD,   2'd3, 16'h1234, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_CLEAR, 2'd3, 16'h0000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_NONE,  2'd0, 16'hFFFF, 5'd16, 8'hFF}, 1'b1, NO_RESULT},
    '{'{CMD_ADD,   2'd1, 16'h1000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_CLEAR, 2'd0, 16'h0000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd0, 16'hFFF0, 5'd16, 8'h77}, 1'b1, NO_RESULT},
    '{'{CMD_CLEAR, 2'd1, 16'h0000, 5'd1,  8'h00}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd1, 16'h1000, 5'd1,  8'h01}, 1'b1, NO_RESULT},
    '{'{CMD_CHECK, 2'd2, 16'h7FF1, 5'd16, 8'h80}, 1'b0, NO_RESULT}
  };

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [1:0]         cmd_i          = '0;
  logic [KIND_W-1:0]  hook_kind_i    = '0;
  logic [ADDR_W-1:0]  address_i      = '0;
  logic [SIZE_W-1:0]  access_size_i  = '0;
  logic [VALUE_W-1:0] access_value_i = '0;
  logic               result_valid_o;
  logic               hit_o;
  logic               table_full_o;
  logic [ADDR_W-1:0]  hit_address_o;
  logic [SIZE_W-1:0]  hit_size_o;
  logic [VALUE_W-1:0] hit_value_o;
  logic [KIND_W-1:0]  hit_kind_o;

  // Local copy of the watch table.
  logic [ADDR_W-1:0] watch_addr [MAX_WATCHES];
  logic [KIND_W-1:0] watch_kind [MAX_WATCHES];
  logic              watch_live [MAX_WATCHES];

  filter_result_t    expected_results [$];
  logic [ADDR_W-1:0] recent_watch_addrs [$];
  int unsigned       mismatch_count = 0;
  int unsigned       stall_cycles   = 0;

  memory_watch_hook_filter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cmd_i          (cmd_i),
    .hook_kind_i    (hook_kind_i),
    .address_i      (address_i),
    .access_size_i  (access_size_i),
    .access_value_i (access_value_i),
    .result_valid_o (result_valid_o),
    .hit_o          (hit_o),
    .table_full_o   (table_full_o),
    .hit_address_o  (hit_address_o),
    .hit_size_o     (hit_size_o),
    .hit_value_o    (hit_value_o),
    .hit_kind_o     (hit_kind_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Applies one item to the local watch table and returns its result.
  function automatic filter_result_t predict_filter(access_item_t it);
    filter_result_t   res;
    logic [END_W-1:0] end_addr;
    bit               done;
    res      = '0;
    done     = 1'b0;
    end_addr = END_W'(it.addr) + END_W'(it.size);
    if (it.kind >= HOOK_KINDS) return res;
    case (it.cmd)
      CMD_CLEAR: begin
        for (int i = 0; i < MAX_WATCHES; i++)
          if (watch_live[i] && watch_kind[i] == it.kind) watch_live[i] = 1'b0;
      end
      CMD_ADD: begin
        for (int i = 0; i < MAX_WATCHES; i++) begin
          if (!done && !watch_live[i]) begin
            watch_addr[i] = it.addr;
            watch_kind[i] = it.kind;
            watch_live[i] = 1'b1;
            done          = 1'b1;
          end
        end
        res.table_full = !done;
      end
      CMD_CHECK: begin
        // The end of the range is 17 bits wide, so it never wraps.
        for (int i = 0; i < MAX_WATCHES; i++)
          if (watch_live[i] && watch_kind[i] == it.kind && watch_addr[i] >= it.addr &&
              END_W'(watch_addr[i]) < end_addr) done = 1'b1;
        if (done) res = '{1'b1, 1'b0, it.addr, it.size, it.value, it.kind};
      end
      default: ;
    endcase
    return res;
  endfunction

  // Half of the addresses land close to a recently watched one so that checks hit often.
  function automatic access_item_t random_access(bit force_add);
    access_item_t      it;
    int unsigned       roll;
    logic [ADDR_W-1:0] base;
    roll     = $urandom_range(99);
    it.kind  = KIND_W'($urandom_range(HOOK_KINDS - 1));
    it.value = VALUE_W'($urandom);
    it.size  = SIZE_W'($urandom_range(16, 1));
    if (force_add || roll < 25) it.cmd = CMD_ADD;
    else if (roll < 33) it.cmd = CMD_CLEAR;
    else it.cmd = CMD_CHECK;
    if ($urandom_range(99) < 6)
      it.size = $urandom_range(1) ? SIZE_W'(0) : SIZE_W'($urandom_range(31, 17));
    roll = $urandom_range(99);
    if (recent_watch_addrs.size() != 0 && roll < 50) begin
      base    = recent_watch_addrs[$urandom_range(recent_watch_addrs.size() - 1)];
      it.addr = base + ADDR_W'($urandom_range(4)) - ADDR_W'($urandom_range(18));
    end else if (roll < 65) begin
      it.addr = $urandom_range(1) ? ADDR_W'($urandom_range(31))
                                  : 16'hFFFF - ADDR_W'($urandom_range(31));
    end else begin
      it.addr = ADDR_W'($urandom);
    end
    if (it.cmd == CMD_ADD) begin
      recent_watch_addrs = {recent_watch_addrs, it.addr};
      if (recent_watch_addrs.size() > 16) void'(recent_watch_addrs.pop_front());
    end
    return it;
  endfunction

  function automatic int unsigned idle_gap(int unsigned pct);
    if ($urandom_range(99) < pct) return $urandom_range(MAX_GAP, 1);
    return 0;
  endfunction

  // Holds the item on the ports until the block takes it.
  task automatic send_access(access_item_t it, filter_result_t want, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start          <= 1'b1;
    cmd_i          <= it.cmd;
    hook_kind_i    <= it.kind;
    address_i      <= it.addr;
    access_size_i  <= it.size;
    access_value_i <= it.value;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_results = {expected_results, want};
  endtask

  task automatic compare_field(string name, logic [ADDR_W-1:0] want_v,
                               logic [ADDR_W-1:0] seen_v);
    if (seen_v !== want_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want_v, seen_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    filter_result_t seen;
    filter_result_t want;
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (rst_ni && result_valid_o) begin
      seen = '{hit_o, table_full_o, hit_address_o, hit_size_o, hit_value_o, hit_kind_o};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, seen);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("hit", ADDR_W'(want.hit), ADDR_W'(seen.hit));
        compare_field("table_full", ADDR_W'(want.table_full), ADDR_W'(seen.table_full));
        compare_field("hit_address", want.addr, seen.addr);
        compare_field("hit_size", ADDR_W'(want.size), ADDR_W'(seen.size));
        compare_field("hit_value", ADDR_W'(want.value), ADDR_W'(seen.value));
        compare_field("hit_kind", ADDR_W'(want.kind), ADDR_W'(seen.kind));
      end
    end
  end

  initial begin
    do @(posedge clk_i); while (stall_cycles < STALL_LIMIT);
    $display("%0t: no item or result moved for %0d cycles", $time, STALL_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    access_item_t   item;
    filter_result_t want;
    int unsigned    done_items;
    int unsigned    burst_left;
    int unsigned    idle_pct;
    bit             noise;
    for (int i = 0; i < MAX_WATCHES; i++) watch_live[i] = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DIRECTED_N; r++) begin
      want = predict_filter(DIRECTED_ROWS[r].item);
      if (DIRECTED_ROWS[r].typed) want = DIRECTED_ROWS[r].want;
      send_access(DIRECTED_ROWS[r].item, want, idle_gap(14));
    end

    // Let the block run dry once before the random part.
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);

    done_items = 0;
    burst_left = 0;
    while (done_items < RANDOM_ITEMS) begin
      idle_pct = IDLE_PCT[(done_items / PHASE_ITEMS) % 4];
      // Runs of adds fill the table so that dropped adds show up.
      if (burst_left == 0 && $urandom_range(99) == 0) burst_left = $urandom_range(70, 30);
      item  = random_access(burst_left != 0);
      noise = $urandom_range(99) < 5;
      if (noise) begin
        if ($urandom_range(1)) item.kind = KIND_W'(3);
        else item.cmd = CMD_NONE;
      end
      want = predict_filter(item);
      send_access(item, want, idle_gap(idle_pct));
      if (!noise) begin
        done_items++;
        if (burst_left != 0) burst_left--;
      end
    end

    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
